// ----- rtl/core/sfmf_pkg.sv -----
// ----------------------------------------------------------------------------
// sfmf_pkg: shared types and constants of the substring first-match finder
// Register indexes, field widths, the queue word and a pattern byte helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmf_pkg;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int PAT_BYTES   = 16;
   localparam int PAT_W       = 8 * PAT_BYTES;
   localparam int LEN_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

   // One classified text byte, passed from the front part to the back part.
   typedef struct packed {
      logic                hit;
      logic                last;
      logic [OFFSET_W-1:0] start;
   } queue_word_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                     input logic [3:0] j);
      pattern_byte = pat[j*BYTE_W +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sfmf_if.sv -----
// ----------------------------------------------------------------------------
// sfmf_if: stream channels of the substring first-match finder
// Request channel of text bytes and response channel of search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sfmf_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [15:0] match_offset;

   modport source (output valid, output match_found, output match_offset, input ready);
   modport sink   (input valid, input match_found, input match_offset, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfmf_front.sv -----
// ----------------------------------------------------------------------------
// sfmf_front: window, byte count and pattern compare
// Holds the pattern registers, shifts each text byte into the window and
// classifies it as a match end or not.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmf_front import sfmf_pkg::*; #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [BYTE_W-1:0]      in_byte,
   input  wire logic                   in_last,
   output logic                        push,
   output queue_word_type              push_word,
   input  wire logic                   queue_full
);

   localparam int SEEN_W  = POSITION_BITS + 1;
   localparam int LEN_CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

   logic [PAT_W-1:0]  pattern_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [BYTE_W-1:0] window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] window_in [MAX_PATTERN];
   logic [SEEN_W-1:0] seen_ff;
   logic [SEEN_W-1:0] seen_in;
   logic [SEEN_W-1:0] seen_sat;
   logic [SEEN_W-1:0] start;
   logic              length_ok;
   logic              bytes_ok;
   logic              window_ok;

   assign in_ready = ~queue_full;
   assign push     = in_valid & in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PATTERN_LOW:    pattern_ff[CSR_DATA_W-1:0]     <= csr_data;
            REG_PATTERN_HIGH:   pattern_ff[PAT_W-1:CSR_DATA_W] <= csr_data;
            REG_PATTERN_LENGTH: length_ff                      <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // The newest byte enters at index 0.
   always_comb begin
      window_in[0] = in_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   assign seen_sat  = (seen_ff == '1) ? seen_ff : seen_ff + SEEN_W'(1);
   assign length_ok = (length_ff != '0) && (length_ff <= LEN_W'(LEN_CAP));
   assign bytes_ok  = seen_sat >= SEEN_W'(length_ff);
   assign start     = seen_sat - SEEN_W'(length_ff);

   // Window entry k holds pattern byte length-1-k.
   always_comb begin
      logic [3:0] idx;
      idx       = '0;
      window_ok = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (k < LEN_CAP) begin
            if (LEN_W'(k) < length_ff) begin
               idx = 4'(length_ff - LEN_W'(k) - LEN_W'(1));
               if (window_in[k] != pattern_byte(pattern_ff, idx)) begin
                  window_ok = 1'b0;
               end
            end
         end
      end
   end

   assign push_word.hit   = length_ok & bytes_ok & window_ok & ~start[POSITION_BITS];
   assign push_word.last  = in_last;
   assign push_word.start = OFFSET_W'(start);

   assign seen_in = in_last ? '0 : seen_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_ff[k] <= '0;
         end
      end else if (push) begin
         seen_ff <= seen_in;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sfmf_queue.sv -----
// ----------------------------------------------------------------------------
// sfmf_queue: two-entry queue between front and back parts
// Register-based first-in first-out store of classified bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmf_queue import sfmf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire queue_word_type push_word,
   output logic          full,
   output logic          not_empty,
   input  wire logic     pop,
   output queue_word_type pop_word
);

   queue_word_type store_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_word  = store_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sfmf_back.sv -----
// ----------------------------------------------------------------------------
// sfmf_back: first-match tracking and result register
// Keeps the first hit of the current text and emits one result per text.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmf_back import sfmf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          word_valid,
   input  wire queue_word_type word,
   output logic               pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic               out_found,
   output logic [OFFSET_W-1:0] out_offset
);

   logic                seen_ff;
   logic                seen_in;
   logic [OFFSET_W-1:0] first_ff;
   logic [OFFSET_W-1:0] first_in;
   logic                valid_ff;
   logic                valid_in;
   logic                found_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                take_hit;

   // A last word needs the result register free; other words always drain.
   assign pop      = word_valid & (~word.last | ~valid_ff | out_ready);
   assign take_hit = ~seen_ff & word.hit;

   assign seen_in  = (pop & word.last) ? 1'b0 : (seen_ff | (pop & take_hit));
   assign first_in = (pop & word.last) ? '0 : ((pop & take_hit) ? word.start : first_ff);
   assign valid_in = (pop & word.last) | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         first_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         first_ff <= first_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop & word.last) begin
         found_ff  <= seen_ff | word.hit;
         offset_ff <= seen_ff ? first_ff : (word.hit ? word.start : '0);
      end
   end

   assign out_valid  = valid_ff;
   assign out_found  = found_ff;
   assign out_offset = offset_ff;

endmodule

`default_nettype wire

// ----- rtl/core/substring_first_match_finder_top.sv -----
// ----------------------------------------------------------------------------
// substring_first_match_finder_top: first occurrence of a pattern in a text
// Streams text bytes through a sliding window, compares it with the
// configured pattern and reports the offset of the first match per text.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents                    Moves when
//   req_if    in         text_byte, end_of_text           valid and ready high
//   rsp_if    out        match_found, match_offset        valid and ready high
//   csr_*     in         csr_index, csr_data              csr_we high
//
// One text word is taken per cycle while the queue has room. A word is
// classified in the cycle it is taken and waits in the queue for the back
// part; when the last word of a text is popped, its result word is
// registered and then offered on rsp_if. Input stalls only when a last
// word waits behind a result held on rsp_if and one more word fills the queue.
// Reset clears the window, the counters, the queue and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_first_match_finder_top import sfmf_pkg::*; #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   sfmf_req_if.sink                    req_if,
   sfmf_rsp_if.source                  rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // Classified words flow from the front part through the queue.
   queue_word_type push_word;
   queue_word_type pop_word;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_not_empty;

   // The front part owns the pattern registers, the window and the count.
   sfmf_front #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_byte    (req_if.text_byte),
      .in_last    (req_if.end_of_text),
      .push       (push),
      .push_word  (push_word),
      .queue_full (queue_full)
   );

   sfmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .pop_word  (pop_word)
   );

   // The back part keeps the first hit and holds the result word.
   sfmf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (queue_not_empty),
      .word       (pop_word),
      .pop        (pop),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_found  (rsp_if.match_found),
      .out_offset (rsp_if.match_offset)
   );

endmodule

`default_nettype wire

// ----- dv/sfmf_search_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfmf_search_checker: result predictor and comparator for the match finder
// Watches the text and result channels and the register port, keeps its own
// copy of the search state and compares every result word with the oldest
// predicted one.
// ----------------------------------------------------------------------------

module sfmf_search_checker import sfmf_pkg::*; #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   sfmf_req_if                    req_if,
   sfmf_rsp_if                    rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     failures,
   output int                     pending_results
);

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
   } search_result_type;

   search_result_type   awaited[$];
   int                  error_count = 0;

   logic [BYTE_W-1:0]   window_q [MAX_PATTERN];
   logic [16:0]         text_count;
   logic                hit_seen;
   logic [OFFSET_W-1:0] hit_offset;
   logic [63:0]         pat_low;
   logic [63:0]         pat_high;
   logic [LEN_W-1:0]    pat_len;

   initial begin
      failures        = 0;
      pending_results = 0;
   end

   // True when the newest pat_len bytes of the current text spell the pattern.
   function automatic logic window_holds_pattern();
      logic [PAT_W-1:0] pat;
      pat = {pat_high, pat_low};
      if (pat_len == 0 || pat_len > MAX_PATTERN || pat_len > PAT_BYTES)
         return 1'b0;
      if (text_count < pat_len)
         return 1'b0;
      for (int j = 0; j < pat_len; j++)
         if (window_q[pat_len - 1 - j] != pat[j*BYTE_W +: BYTE_W])
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic note_error(input string what);
      if (error_count < 10)
         $display("%0t: result error: %s", $realtime, what);
      error_count++;
   endtask

   task automatic absorb_text_byte(input logic [BYTE_W-1:0] value, input logic last);
      logic [16:0]       start;
      search_result_type res;
      for (int i = MAX_PATTERN - 1; i > 0; i--)
         window_q[i] = window_q[i-1];
      window_q[0] = value;
      // The byte count saturates, so positions in very long texts stay far.
      if (text_count != '1)
         text_count++;
      if (!hit_seen && window_holds_pattern()) begin
         start = text_count - 17'(pat_len);
         if (start < (17'd1 << POSITION_BITS)) begin
            hit_seen   = 1'b1;
            hit_offset = start[OFFSET_W-1:0];
         end
      end
      if (last) begin
         res.found  = hit_seen;
         res.offset = hit_seen ? hit_offset : '0;
         awaited.push_back(res);
         text_count = '0;
         hit_seen   = 1'b0;
         hit_offset = '0;
      end
   endtask

   task automatic check_result(input logic found, input logic [OFFSET_W-1:0] offset);
      search_result_type want;
      if (awaited.size() == 0) begin
         note_error($sformatf("unexpected word found=%0b offset=%0d", found, offset));
      end else begin
         want = awaited.pop_front();
         if (want.found !== found || want.offset !== offset)
            note_error($sformatf("expected found=%0b offset=%0d, got found=%0b offset=%0d",
                                 want.found, want.offset, found, offset));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited.delete();
         for (int i = 0; i < MAX_PATTERN; i++)
            window_q[i] = '0;
         text_count = '0;
         hit_seen   = 1'b0;
         hit_offset = '0;
         pat_low    = '0;
         pat_high   = '0;
         pat_len    = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PATTERN_LOW:    pat_low  = csr_data;
               REG_PATTERN_HIGH:   pat_high = csr_data;
               REG_PATTERN_LENGTH: pat_len  = csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         // A result can never belong to a word taken at the same edge.
         if (rsp_if.valid && rsp_if.ready)
            check_result(rsp_if.match_found, rsp_if.match_offset);
         if (req_if.valid && req_if.ready)
            absorb_text_byte(req_if.text_byte, req_if.end_of_text);
      end
      pending_results <= awaited.size();
      failures        <= error_count;
   end

endmodule

// ----- dv/tb_substring_first_match_finder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_substring_first_match_finder_top: testbench of the substring finder
// Programs patterns, streams directed and random texts through the block
// under varying back-pressure and lets the checker compare every result.
// ----------------------------------------------------------------------------

module tb_substring_first_match_finder_top;
   import sfmf_pkg::*;

   // The index past the three registers is decoded by nobody; writing it must
   // leave the search untouched.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   // Generous bound on the run length, even with heavy idling on both sides.
   localparam int CYCLE_LIMIT     = 200_000;
   // Quiet cycles after the last result, enough for the pipeline and its queue
   // to empty of words that cause no result.
   localparam int SETTLE_CYCLES   = 16;
   localparam int WORDS_PER_ROUND = 150;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     failures;
   int                     pending_results;
   int                     cycle_count = 0;

   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;

   // Pattern as last programmed, used only to shape the random texts.
   logic [PAT_W-1:0]       cur_pat;
   int                     cur_len;
   logic [BYTE_W-1:0]      text_buf[$];

   sfmf_req_if req_if();
   sfmf_rsp_if rsp_if();

   substring_first_match_finder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sfmf_search_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random; the rate follows the current phase.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offers one text word and returns at the edge that takes it. Valid is
   // only lowered when an idle gap is inserted, so back-to-back words never
   // see valid dropped and raised within one time step.
   task automatic send_word(input logic [BYTE_W-1:0] value, input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid       <= 1'b1;
      req_if.text_byte   <= value;
      req_if.end_of_text <= last;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_word(text_buf[i], i == text_buf.size() - 1);
   endtask

   // Holds the sender until every predicted result has come back, then lets
   // the pipeline run dry. The first edge is always taken so that the count
   // reflects a word accepted at the edge just before the call.
   task automatic drain();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers plus the spare index on consecutive edges.
   // Only called with the block idle.
   task automatic program_pattern(input logic [63:0] low, input logic [63:0] high,
                                  input logic [63:0] len_data);
      csr_we    <= 1'b1;
      csr_index <= REG_PATTERN_LOW;
      csr_data  <= low;
      @(posedge clock);
      csr_index <= REG_PATTERN_HIGH;
      csr_data  <= high;
      @(posedge clock);
      csr_index <= REG_PATTERN_LENGTH;
      csr_data  <= len_data;
      @(posedge clock);
      csr_index <= REG_SPARE;
      csr_data  <= {$urandom, $urandom};
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_pat = {high, low};
      cur_len = int'(len_data[LEN_W-1:0]);
   endtask

   // Builds one random text. Most texts draw most bytes from the pattern's
   // own alphabet, and with a valid length many carry a planted copy of the
   // pattern, sometimes with its last byte spoiled; some are plain noise.
   task automatic make_text();
      int               n;
      int               at;
      int               alpha;
      bit               noise;
      logic [BYTE_W-1:0] pb;
      text_buf.delete();
      noise = ($urandom_range(99) < 15);
      alpha = (cur_len >= 1 && cur_len <= PAT_BYTES) ? cur_len : 4;
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         if (!noise && $urandom_range(99) < 70)
            pb = cur_pat[$urandom_range(alpha - 1)*BYTE_W +: BYTE_W];
         else
            pb = BYTE_W'($urandom);
         text_buf.push_back(pb);
      end
      if (!noise && cur_len >= 1 && cur_len <= PAT_BYTES && $urandom_range(99) < 60) begin
         while (text_buf.size() < cur_len)
            text_buf.push_back(BYTE_W'($urandom));
         at = $urandom_range(text_buf.size() - cur_len);
         for (int j = 0; j < cur_len; j++)
            text_buf[at + j] = cur_pat[j*BYTE_W +: BYTE_W];
         if ($urandom_range(99) < 20)
            text_buf[at + cur_len - 1] = ~cur_pat[(cur_len - 1)*BYTE_W +: BYTE_W];
      end
   endtask

   initial begin
      int          round_no;
      int          len_pick;
      int          sent;
      logic [63:0] pat_lo;
      logic [63:0] pat_hi;
      logic [63:0] len_data;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.text_byte   = '0;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = REG_PATTERN_LOW;
      csr_data           = '0;
      cur_pat            = '0;
      cur_len            = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts run with the first idling profile.
      send_idle_pct = 15;
      recv_idle_pct = 64;

      // Registers still hold their reset values: the empty pattern never
      // matches, even on the extreme byte values.
      text_buf = '{8'h00, 8'hFF};
      send_text();

      drain();
      program_pattern(64'h0000_0000_4443_4241, 64'hFFFF_FFFF_FFFF_FFFF, 64'd4);
      // The pattern right at the first byte must be found at offset zero.
      text_buf = '{8'h41, 8'h42, 8'h43, 8'h44};
      send_text();
      // A text shorter than the pattern cannot match.
      text_buf = '{8'h41, 8'h42, 8'h43};
      send_text();
      // The window keeps bytes across texts, but a match may not reach back
      // into the previous text.
      text_buf = '{8'h41, 8'h42};
      send_text();
      text_buf = '{8'h43, 8'h44};
      send_text();
      // Two occurrences after a false start: only the first one counts.
      text_buf = '{8'h41, 8'h41, 8'h42, 8'h43, 8'h44, 8'h41, 8'h42, 8'h43, 8'h44};
      send_text();
      // A text of a single word.
      text_buf = '{8'hFF};
      send_text();

      // Random part: three idling profiles with four pattern settings each.
      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         case (phase_no)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int round = 0; round < 4; round++) begin
            round_no = phase_no * 4 + round;
            // Full length, single byte, empty and overlong settings are all
            // visited; the other rounds pick a length in between.
            case (round_no)
               0, 6, 11: len_pick = PAT_BYTES;
               1:        len_pick = 1;
               2:        len_pick = 0;
               7:        len_pick = $urandom_range(PAT_BYTES + 1, 31);
               default:  len_pick = $urandom_range(2, PAT_BYTES - 1);
            endcase
            pat_lo = {$urandom, $urandom};
            pat_hi = {$urandom, $urandom};
            if (round_no == 4) begin
               pat_lo = '0;
               pat_hi = '0;
            end else if (round_no == 6) begin
               pat_lo = '1;
               pat_hi = '1;
            end
            // Bits above the length field are random and must be ignored.
            len_data = {$urandom, $urandom};
            len_data[LEN_W-1:0] = LEN_W'(len_pick);

            drain();
            program_pattern(pat_lo, pat_hi, len_data);
            sent = 0;
            while (sent < WORDS_PER_ROUND) begin
               make_text();
               sent += text_buf.size();
               send_text();
               if ($urandom_range(19) == 0)
                  drain();
            end
         end
      end

      drain();
      if (failures == 0 && pending_results == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
